@@ hw/rtl/ptrs_pkg.sv @@
// ----------------------------------------------------------------------------
// Periodic task release scheduler package
// Shared word types, status and request codes, and register map constants.
// ----------------------------------------------------------------------------
package ptrs_pkg;

   // Request codes.
   localparam logic REQ_ADD  = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   // Result status codes.
   localparam logic [1:0] STATUS_RELEASED = 2'd0;
   localparam logic [1:0] STATUS_ADDED    = 2'd1;
   localparam logic [1:0] STATUS_FULL     = 2'd2;
   localparam logic [1:0] STATUS_IDLE     = 2'd3;

   // Register map: register index is paddr[2].
   localparam int           CSR_ADDR_W        = 3;
   localparam int           CSR_DATA_W        = 32;
   localparam logic         CSR_IDX_CAPACITY  = 1'b0;
   localparam logic         CSR_IDX_STATUS    = 1'b1;
   localparam logic [4:0]   CAPACITY_RESET    = 5'd16;

   typedef struct packed {
      logic        req_type;
      logic [31:0] first_offset;
      logic [31:0] run_period;
      logic        forced_timing;
   } req_word_type;

   typedef struct packed {
      logic [1:0] status;
      logic [3:0] task_index;
      logic       was_forced;
      logic       last;
   } rsp_word_type;

   // One table entry as read from the task table.
   typedef struct packed {
      logic [31:0] delay;
      logic [31:0] period;
      logic        forced;
   } entry_type;

   // Table write controls. entry_en writes period and forced flag.
   typedef struct packed {
      logic        delay_en;
      logic        entry_en;
      logic [31:0] delay;
      logic [31:0] period;
      logic        forced;
   } tbl_wr_type;

endpackage

@@ hw/rtl/periodic_task_release_scheduler_core.sv @@
// ----------------------------------------------------------------------------
// Periodic task release scheduler
// Task table with add and tick requests; releases due tasks, forced first.
// ----------------------------------------------------------------------------
// An add word writes its entry once the result side can take its result. A
// tick word walks the used entries twice through the single table port,
// reading and then updating each entry per pass, and the result side can
// stall it. The first pass decrements every delay and releases due forced
// tasks; the second releases due normal tasks. One word is processed at a
// time and req_stall stays high until its last result is registered.
// Register 0 (byte address 0) is task_capacity; byte address 4 reads the
// sticky table-full flag.
module periodic_task_release_scheduler_core
   import ptrs_pkg::*;
#(
   parameter int MAX_TASKS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_word_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_word_type          rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CNT_W = $clog2(MAX_TASKS + 1);
   localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ADD,
      S_READ,
      S_EXEC,
      S_DONE
   } state_type;

   state_type    state_ff, state_in;
   req_word_type req_hold_ff, req_hold_in;
   logic [CNT_W-1:0] used_ff, used_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic             pass_forced_ff, pass_forced_in;
   logic             full_ff, full_in;
   logic [4:0]       cap_ff;
   logic             pend_valid_ff, pend_valid_in;
   logic [IDX_W-1:0] pend_idx_ff, pend_idx_in;
   logic             pend_forced_ff, pend_forced_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_word_type     rsp_data_ff, rsp_data_in;

   logic             out_free;
   logic             add_ok;
   logic             last_entry;
   logic [CNT_W-1:0] idx_nxt;
   logic             rd_en;
   entry_type        rd_entry;
   logic [IDX_W-1:0] wr_addr;
   tbl_wr_type       wr;
   logic [31:0]      new_delay;
   logic             hit;
   logic             csr_index;
   logic             csr_write;

   ptrs_table #(
      .DEPTH (MAX_TASKS),
      .IDX_W (IDX_W)
   ) u_table (
      .clock    (clock),
      .rd_en    (rd_en),
      .rd_addr  (idx_ff[IDX_W-1:0]),
      .rd_entry (rd_entry),
      .wr_addr  (wr_addr),
      .wr       (wr)
   );

   // The tick decrement is folded into the forced pass.
   ptrs_alu u_alu (
      .entry       (rd_entry),
      .tick_dec    (pass_forced_ff),
      .want_forced (pass_forced_ff),
      .new_delay   (new_delay),
      .hit         (hit)
   );

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign add_ok     = (CMP_W'(used_ff) < CMP_W'(cap_ff)) &&
                       (CMP_W'(used_ff) < CMP_W'(MAX_TASKS));
   assign idx_nxt    = idx_ff + CNT_W'(1);
   assign last_entry = (idx_nxt == used_ff);
   assign rd_en      = (state_ff == S_READ);
   assign req_stall  = (state_ff != S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   always_comb begin
      state_in       = state_ff;
      req_hold_in    = req_hold_ff;
      used_in        = used_ff;
      idx_in         = idx_ff;
      pass_forced_in = pass_forced_ff;
      full_in        = full_ff;
      pend_valid_in  = pend_valid_ff;
      pend_idx_in    = pend_idx_ff;
      pend_forced_in = pend_forced_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_data_in    = rsp_data_ff;
      wr_addr        = idx_ff[IDX_W-1:0];
      wr             = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_hold_in = req_data;
               if (req_data.req_type == REQ_ADD) begin
                  state_in = S_ADD;
               end else begin
                  pend_valid_in  = 1'b0;
                  pass_forced_in = 1'b1;
                  idx_in         = '0;
                  state_in       = (used_ff == '0) ? S_DONE : S_READ;
               end
            end
         end
         S_ADD: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_data_in.last = 1'b1;
               if (add_ok) begin
                  wr_addr     = used_ff[IDX_W-1:0];
                  wr.delay_en = 1'b1;
                  wr.entry_en = 1'b1;
                  wr.delay    = req_hold_ff.first_offset;
                  wr.period   = req_hold_ff.run_period;
                  wr.forced   = req_hold_ff.forced_timing;
                  used_in     = used_ff + CNT_W'(1);
                  rsp_data_in.status     = STATUS_ADDED;
                  rsp_data_in.task_index = 4'(used_ff[IDX_W-1:0]);
                  rsp_data_in.was_forced = req_hold_ff.forced_timing;
               end else begin
                  full_in = 1'b1;
                  rsp_data_in.status     = STATUS_FULL;
                  rsp_data_in.task_index = '0;
                  rsp_data_in.was_forced = 1'b0;
               end
               state_in = S_IDLE;
            end
         end
         S_READ: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            // A release is held back one step so the final one can carry last.
            if (!(hit && pend_valid_ff && !out_free)) begin
               wr.delay_en = 1'b1;
               wr.delay    = new_delay;
               if (hit) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in           = 1'b1;
                     rsp_data_in.status     = STATUS_RELEASED;
                     rsp_data_in.task_index = 4'(pend_idx_ff);
                     rsp_data_in.was_forced = pend_forced_ff;
                     rsp_data_in.last       = 1'b0;
                  end
                  pend_valid_in  = 1'b1;
                  pend_idx_in    = idx_ff[IDX_W-1:0];
                  pend_forced_in = pass_forced_ff;
               end
               if (last_entry) begin
                  if (pass_forced_ff) begin
                     pass_forced_in = 1'b0;
                     idx_in         = '0;
                     state_in       = S_READ;
                  end else begin
                     state_in = S_DONE;
                  end
               end else begin
                  idx_in   = idx_nxt;
                  state_in = S_READ;
               end
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_data_in.last = 1'b1;
               if (pend_valid_ff) begin
                  rsp_data_in.status     = STATUS_RELEASED;
                  rsp_data_in.task_index = 4'(pend_idx_ff);
                  rsp_data_in.was_forced = pend_forced_ff;
               end else begin
                  rsp_data_in.status     = STATUS_IDLE;
                  rsp_data_in.task_index = '0;
                  rsp_data_in.was_forced = 1'b0;
               end
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         used_ff        <= '0;
         idx_ff         <= '0;
         pass_forced_ff <= 1'b0;
         full_ff        <= 1'b0;
         pend_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         used_ff        <= used_in;
         idx_ff         <= idx_in;
         pass_forced_ff <= pass_forced_in;
         full_ff        <= full_in;
         pend_valid_ff  <= pend_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      req_hold_ff    <= req_hold_in;
      pend_idx_ff    <= pend_idx_in;
      pend_forced_ff <= pend_forced_in;
      rsp_data_ff    <= rsp_data_in;
   end

   // Register port.
   assign csr_index  = csr_paddr[2];
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite &&
                       (csr_index == CSR_IDX_CAPACITY);

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAPACITY_RESET;
      end else if (csr_write) begin
         cap_ff <= csr_pwdata[4:0];
      end
   end

   always_comb begin
      unique case (csr_index)
         CSR_IDX_CAPACITY: csr_prdata = CSR_DATA_W'(cap_ff);
         CSR_IDX_STATUS:   csr_prdata = CSR_DATA_W'(full_ff);
         default:          csr_prdata = '0;
      endcase
   end

endmodule

@@ hw/rtl/ptrs_table.sv @@
// ----------------------------------------------------------------------------
// Task table
// Delay, period and forced-flag storage with one write and one registered read.
// ----------------------------------------------------------------------------
module ptrs_table
   import ptrs_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int IDX_W = 4
) (
   input  logic             clock,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_addr,
   output entry_type        rd_entry,
   input  logic [IDX_W-1:0] wr_addr,
   input  tbl_wr_type       wr
);

   logic [31:0] delay_mem_ff  [DEPTH];
   logic [31:0] period_mem_ff [DEPTH];
   logic        forced_mem_ff [DEPTH];
   entry_type   rd_entry_ff;

   always_ff @(posedge clock) begin
      if (wr.delay_en) begin
         delay_mem_ff[wr_addr] <= wr.delay;
      end
      if (wr.entry_en) begin
         period_mem_ff[wr_addr] <= wr.period;
         forced_mem_ff[wr_addr] <= wr.forced;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_entry_ff.delay  <= delay_mem_ff[rd_addr];
         rd_entry_ff.period <= period_mem_ff[rd_addr];
         rd_entry_ff.forced <= forced_mem_ff[rd_addr];
      end
   end

   assign rd_entry = rd_entry_ff;

endmodule

@@ hw/rtl/ptrs_alu.sv @@
// ----------------------------------------------------------------------------
// Entry update unit
// Decrements a delay, detects a due task and computes its reload value.
// ----------------------------------------------------------------------------
module ptrs_alu
   import ptrs_pkg::*;
(
   input  entry_type   entry,
   input  logic        tick_dec,
   input  logic        want_forced,
   output logic [31:0] new_delay,
   output logic        hit
);

   logic [31:0] dec_delay;

   always_comb begin
      dec_delay = entry.delay;
      if (tick_dec && (entry.delay != 32'd0)) begin
         dec_delay = entry.delay - 32'd1;
      end
      hit = (entry.forced == want_forced) && (dec_delay == 32'd0);
      new_delay = dec_delay;
      if (hit) begin
         // A zero period behaves as a period of one.
         new_delay = (entry.period == 32'd0) ? 32'd0 : entry.period - 32'd1;
      end
   end

endmodule

@@ hw/rtl/ptrs_checker.sv @@
// ----------------------------------------------------------------------------
// Scheduler port checker
// Watches the word channels of the scheduler core; bound to the top level.
// ----------------------------------------------------------------------------
module ptrs_checker
   import ptrs_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_word_type rsp_data
);

   // A stalled result word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   // The core is busy in the cycle after it takes a word.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while previous word still in work");

   // Added, full and nothing-due results are single words.
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == STATUS_ADDED ||
                    rsp_data.status == STATUS_FULL ||
                    rsp_data.status == STATUS_IDLE) |-> rsp_data.last)
      else $error("single result word without last");

   // Full and nothing-due results carry no task.
   a_no_task: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == STATUS_FULL ||
                    rsp_data.status == STATUS_IDLE) |->
      (rsp_data.task_index == 4'd0) && !rsp_data.was_forced)
      else $error("task fields set on a word that names no task");

endmodule

bind periodic_task_release_scheduler_core ptrs_checker u_ptrs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

@@ dv/tb_periodic_task_release_scheduler_core.sv @@
// ----------------------------------------------------------------------------
// Testbench for the periodic task release scheduler core
// Drives add and tick words through the request channel and changes the task
// capacity over the register port between phases. A directed table covers
// the empty tick, table full, zero period, forced-before-normal ordering and
// capacity limits; random phases follow. Every result word is compared with
// its row's typed expectation, if any, or a scheduler model in the testbench.
// ----------------------------------------------------------------------------
module tb_periodic_task_release_scheduler_core;
   timeunit 1ns;
   timeprecision 1ps;
   import ptrs_pkg::*;

   localparam int TABLE_DEPTH    = 16;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 4 * TABLE_DEPTH + 16;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_WORDS    = 25;
   localparam logic [CSR_ADDR_W-1:0] CAPACITY_ADDR = {CSR_IDX_CAPACITY, 2'b00};

   typedef enum logic [1:0] {STEP_ADD, STEP_TICK, STEP_CAPACITY} step_kind_type;

   typedef struct {
      step_kind_type kind;
      req_word_type  word;
      logic [4:0]    capacity;
      bit            typed;
      rsp_word_type  want;
   } plan_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_word_type          req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_word_type          rsp_data;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // A hand-typed expectation travels alongside the word it belongs to.
   logic                  typed_valid = 1'b0;
   rsp_word_type          typed_word = '0;

   // Scheduler model state.
   logic [31:0]  delay_model [TABLE_DEPTH];
   logic [31:0]  period_model [TABLE_DEPTH];
   logic         forced_model [TABLE_DEPTH];
   int           used_tasks = 0;
   logic [4:0]   capacity_model = CAPACITY_RESET;
   rsp_word_type step_results[$];
   rsp_word_type pending_results[$];

   int           errors = 0;
   int           idle_cycles = 0;
   bit           calm = 1'b0;
   plan_row_type plan[$];

   always #6 clock = ~clock;

   periodic_task_release_scheduler_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Computes the result words of one request word and updates the table.
   function automatic void run_scheduler(req_word_type w);
      int           limit;
      logic [31:0]  reload;
      logic         want_forced;
      rsp_word_type r;
      step_results.delete();
      if (w.req_type == REQ_ADD) begin
         limit = (capacity_model > TABLE_DEPTH) ? TABLE_DEPTH : capacity_model;
         if (used_tasks < limit) begin
            delay_model[used_tasks]  = w.first_offset;
            period_model[used_tasks] = w.run_period;
            forced_model[used_tasks] = w.forced_timing;
            r = '{STATUS_ADDED, 4'(used_tasks), w.forced_timing, 1'b1};
            used_tasks++;
         end else begin
            r = '{STATUS_FULL, 4'd0, 1'b0, 1'b1};
         end
         step_results.push_back(r);
      end else begin
         for (int i = 0; i < used_tasks; i++)
            if (delay_model[i] != 0) delay_model[i]--;
         // Forced tasks go out in the first pass, normal tasks in the second.
         for (int pass = 0; pass < 2; pass++) begin
            want_forced = (pass == 0);
            for (int i = 0; i < used_tasks; i++) begin
               if (forced_model[i] == want_forced && delay_model[i] == 0) begin
                  reload = (period_model[i] == 0) ? 32'd1 : period_model[i];
                  delay_model[i] = reload - 32'd1;
                  r = '{STATUS_RELEASED, 4'(i), want_forced, 1'b0};
                  step_results.push_back(r);
               end
            end
         end
         if (step_results.size() == 0) begin
            r = '{STATUS_IDLE, 4'd0, 1'b0, 1'b1};
            step_results.push_back(r);
         end else begin
            step_results[$].last = 1'b1;
         end
      end
   endfunction

   function automatic void check_field(string name, logic [3:0] want, logic [3:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         errors++;
      end
   endfunction

   // Result checking, expectation bookkeeping and the progress watchdog.
   always @(posedge clock) begin
      rsp_word_type exp_w;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               $error("result word with nothing pending: %p", rsp_data);
               errors++;
            end else begin
               exp_w = pending_results.pop_front();
               check_field("status", exp_w.status, rsp_data.status);
               check_field("task_index", exp_w.task_index, rsp_data.task_index);
               check_field("was_forced", exp_w.was_forced, rsp_data.was_forced);
               check_field("last", exp_w.last, rsp_data.last);
            end
         end
         if (req_valid && !req_stall) begin
            run_scheduler(req_data);
            if (typed_valid) begin
               pending_results.push_back(typed_word);
            end else begin
               foreach (step_results[k]) pending_results.push_back(step_results[k]);
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // Result side back-pressure.
   initial begin
      int unsigned hold;
      while (reset) @(posedge clock);
      forever begin
         hold = calm ? 0 : $urandom_range(0, 19);
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
      end
   end

   task automatic send_word(req_word_type w, bit typed, rsp_word_type want);
      int unsigned gap;
      gap = calm ? 0 : $urandom_range(0, 19);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_data    <= w;
      typed_valid <= typed;
      typed_word  <= want;
      do @(posedge clock); while (req_stall !== 1'b0);
   endtask

   // Waits until every pending result has arrived and the core has gone quiet.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(logic [4:0] value);
      logic [31:0] data;
      settle();
      data      = $urandom;
      data[4:0] = value;
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= CAPACITY_ADDR;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      capacity_model = value;
   endtask

   function automatic plan_row_type add_row(logic [31:0] offset, logic [31:0] period,
                                            logic forced, bit typed = 1'b0,
                                            logic [1:0] status = STATUS_ADDED,
                                            logic [3:0] index = 4'd0);
      plan_row_type p;
      p.kind     = STEP_ADD;
      p.word     = '{REQ_ADD, offset, period, forced};
      p.capacity = '0;
      p.typed    = typed;
      p.want     = '{status, index, (status == STATUS_ADDED) ? forced : 1'b0, 1'b1};
      return p;
   endfunction

   function automatic plan_row_type tick_row(bit typed = 1'b0);
      plan_row_type p;
      p.kind     = STEP_TICK;
      p.word     = '{REQ_TICK, 32'd0, 32'd0, 1'b0};
      p.capacity = '0;
      p.typed    = typed;
      p.want     = '{STATUS_IDLE, 4'd0, 1'b0, 1'b1};
      return p;
   endfunction

   function automatic plan_row_type capacity_row(logic [4:0] value);
      plan_row_type p;
      p.kind     = STEP_CAPACITY;
      p.word     = '0;
      p.capacity = value;
      p.typed    = 1'b0;
      p.want     = '0;
      return p;
   endfunction

   initial begin
      logic [4:0]   phase_caps [RANDOM_PHASES];
      req_word_type w;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // An empty table ticks idle; task 0 has a zero period and task 2 never
      // comes due; later rows lower the limit, refuse adds and raise it again.
      plan.push_back(tick_row(1'b1));
      plan.push_back(add_row(32'd0, 32'd0, 1'b0, 1'b1, STATUS_ADDED, 4'd0));
      plan.push_back(add_row(32'd1, 32'd3, 1'b1, 1'b1, STATUS_ADDED, 4'd1));
      plan.push_back(add_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, STATUS_ADDED, 4'd2));
      plan.push_back(add_row(32'd2, 32'hFFFF_FFFF, 1'b0, 1'b1, STATUS_ADDED, 4'd3));
      plan.push_back(tick_row());
      plan.push_back(tick_row());
      plan.push_back(tick_row());
      plan.push_back(tick_row());
      plan.push_back(capacity_row(5'd4));
      plan.push_back(add_row(32'd5, 32'd5, 1'b1, 1'b1, STATUS_FULL));
      plan.push_back(capacity_row(5'd0));
      plan.push_back(add_row(32'd1, 32'd1, 1'b0, 1'b1, STATUS_FULL));
      plan.push_back(capacity_row(5'd2));
      plan.push_back(add_row(32'd0, 32'd2, 1'b1, 1'b1, STATUS_FULL));
      plan.push_back(tick_row());
      plan.push_back(capacity_row(5'd31));
      plan.push_back(add_row(32'd0, 32'd1, 1'b1, 1'b1, STATUS_ADDED, 4'd4));
      plan.push_back(add_row(32'd3, 32'd2, 1'b0, 1'b1, STATUS_ADDED, 4'd5));
      plan.push_back(tick_row());
      plan.push_back(tick_row());
      plan.push_back(capacity_row(5'd16));

      foreach (plan[n]) begin
         if (plan[n].kind == STEP_CAPACITY) write_capacity(plan[n].capacity);
         else send_word(plan[n].word, plan[n].typed, plan[n].want);
      end

      phase_caps = '{5'd16, 5'd0, 5'd9, 5'd31, 5'd0, 5'd12, 5'd2, 5'd16};
      phase_caps[4] = 5'($urandom_range(0, 31));
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         write_capacity(phase_caps[ph]);
         calm = ($urandom_range(0, 3) == 0);
         repeat (PHASE_WORDS) begin
            w.req_type      = ($urandom_range(0, 99) < 35) ? REQ_ADD : REQ_TICK;
            w.first_offset  = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 8);
            w.run_period    = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 10);
            w.forced_timing = 1'($urandom_range(0, 1));
            send_word(w, 1'b0, '0);
         end
      end
      calm = 1'b0;

      settle();
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

@@ periodic_task_release_scheduler_core.f @@
hw/rtl/ptrs_pkg.sv
hw/rtl/ptrs_table.sv
hw/rtl/ptrs_alu.sv
hw/rtl/periodic_task_release_scheduler_core.sv
hw/rtl/ptrs_checker.sv
dv/tb_periodic_task_release_scheduler_core.sv
